### rtl/ptd_pkg.sv
// Shared types and constants of the trial-division prime test unit.
package ptd_pkg;

   localparam int NUMBER_W           = 30;
   // Wide enough for the 8192nd prime (84017).
   localparam int PRIME_W            = 17;
   localparam int SQ_W               = 2 * PRIME_W;
   localparam int NUM_PRIMES_DEFAULT = 4096;
   localparam int FIRST_PRIME        = 2;
   localparam int FIRST_CANDIDATE    = 3;
   localparam int MIN_PRIME_NUMBER   = 2;

   typedef enum logic [2:0] {
      ST_SEED,
      ST_CAND_RUN,
      ST_IDLE,
      ST_TEST_RUN,
      ST_TEST_END
   } ptd_state_type;

   typedef struct packed {
      logic empty;
      logic hit;
   } ptd_chain_status_type;

endpackage

### rtl/ptd_cell.sv
// One restoring-division step: shift in a dividend bit, subtract the divisor if it fits.
module ptd_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [ptd_pkg::PRIME_W-1:0]  in_rem,
   input  logic [ptd_pkg::PRIME_W-1:0]  in_div,
   input  logic                         in_bit,
   output logic                         out_valid,
   output logic [ptd_pkg::PRIME_W-1:0]  out_rem,
   output logic [ptd_pkg::PRIME_W-1:0]  out_div
);
   import ptd_pkg::*;

   logic                 valid_ff;
   logic [PRIME_W-1:0]   rem_ff;
   logic [PRIME_W-1:0]   div_ff;
   logic [PRIME_W:0]     shifted;
   logic [PRIME_W-1:0]   rem_in;

   always_comb begin
      shifted = {in_rem, in_bit};
      if (shifted >= {1'b0, in_div}) begin
         rem_in = PRIME_W'(shifted - {1'b0, in_div});
      end else begin
         rem_in = shifted[PRIME_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= in_div;
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_div   = div_ff;

endmodule

### rtl/ptd_chain.sv
// Row of division cells producing dividend mod prime, one prime entering per cycle.
module ptd_chain (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                inj_valid,
   input  logic [ptd_pkg::PRIME_W-1:0]         inj_div,
   input  logic [ptd_pkg::NUMBER_W-1:0]        dividend,
   output ptd_pkg::ptd_chain_status_type       status
);
   import ptd_pkg::*;

   localparam int CELLS = NUMBER_W;
   localparam int CNT_W = $clog2(CELLS + 1);

   logic [CELLS:0]       valid_w;
   logic [PRIME_W-1:0]   rem_w [CELLS+1];
   logic [PRIME_W-1:0]   div_w [CELLS+1];
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic                 exit_valid;

   assign valid_w[0] = inj_valid;
   assign rem_w[0]   = '0;
   assign div_w[0]   = inj_div;

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      ptd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_w[i]),
         .in_rem    (rem_w[i]),
         .in_div    (div_w[i]),
         .in_bit    (dividend[CELLS-1-i]),
         .out_valid (valid_w[i+1]),
         .out_rem   (rem_w[i+1]),
         .out_div   (div_w[i+1])
      );
   end

   assign exit_valid = valid_w[CELLS];

   // Track requests in flight so the controller knows when the row has drained.
   always_comb begin
      count_in = count_ff;
      if (inj_valid && !exit_valid) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!inj_valid && exit_valid) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign status.empty = (count_ff == '0);
   assign status.hit   = exit_valid && (rem_w[CELLS] == '0);

endmodule

### rtl/trial_division_prime_test_unit.sv
// Top level of the trial-division prime test unit: table fill, control and result register.
//
//   channel | ports                              | direction | meaning
//   --------+------------------------------------+-----------+-----------------------------
//   req     | req_valid req_stall req_number     | in        | 30-bit number to test
//   rsp     | rsp_valid rsp_stall rsp_prime_flag | out       | 1 when the number is prime
//
// After reset the unit builds its own table of the first NUM_PRIMES primes; req_stall
// stays high for that whole fill. For a request, the prime memory feeds one divisor per
// cycle into a 30-cell division row, taking the primes p with p*p <= number in turn until
// one divides it, and the row's delay is paid once at the end. Numbers below two never
// enter the row and go straight to the result.
// The result waits in an output register; a new request is taken while it waits, but the
// next result is held back until the previous one has been taken.
module trial_division_prime_test_unit #(
   parameter int NUM_PRIMES = ptd_pkg::NUM_PRIMES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ptd_pkg::NUMBER_W-1:0]  req_number,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_prime_flag
);
   import ptd_pkg::*;

   localparam int AW = $clog2(NUM_PRIMES);
   localparam int CW = $clog2(NUM_PRIMES + 1);

   // Prime table memory: one write port, one registered read port.
   logic [PRIME_W-1:0]   prime_mem [NUM_PRIMES];

   ptd_state_type         state_ff, state_in;
   logic [CW-1:0]         k_ff, k_in;             // next table index to read
   logic                  stop_ff, stop_in;       // no more divisors for this number
   logic                  found_ff, found_in;     // a divisor was found, or the number is below two
   logic [NUMBER_W-1:0]   test_ff, test_in;       // number or fill candidate under test
   logic [CW-1:0]         fill_count_ff, fill_count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_prime_flag_ff, rsp_prime_flag_in;
   logic                  rd_valid_ff;
   logic [PRIME_W-1:0]    rd_prime_ff;

   logic                  rd_en;
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [PRIME_W-1:0]    mem_wdata;
   logic                  inj_valid;
   logic                  run_active;
   logic                  run_done;
   logic [SQ_W-1:0]       square;
   ptd_chain_status_type  chain_status;

   ptd_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .inj_valid (inj_valid),
      .inj_div   (rd_prime_ff),
      .dividend  (test_ff),
      .status    (chain_status)
   );

   assign square = SQ_W'(rd_prime_ff) * SQ_W'(rd_prime_ff);

   // Trial run is over once nothing is left to issue, nothing is read and the row is empty.
   assign run_done = (stop_ff || (k_ff == fill_count_ff)) && !rd_valid_ff
                     && chain_status.empty;

   always_comb begin
      state_in          = state_ff;
      k_in              = k_ff;
      stop_in           = stop_ff;
      found_in          = found_ff;
      test_in           = test_ff;
      fill_count_in     = fill_count_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_prime_flag_in = rsp_prime_flag_ff;
      rd_en             = 1'b0;
      inj_valid         = 1'b0;
      mem_we            = 1'b0;
      mem_waddr         = fill_count_ff[AW-1:0];
      mem_wdata         = test_ff[PRIME_W-1:0];
      run_active        = (state_ff == ST_CAND_RUN) || (state_ff == ST_TEST_RUN);

      // Drop the result once the receiver takes it.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (run_active) begin
         // Read the next stored prime.
         if (!stop_ff && (k_ff != fill_count_ff)) begin
            rd_en = 1'b1;
            k_in  = k_ff + CW'(1);
         end
         // Feed the prime into the row while its square does not exceed the number.
         if (rd_valid_ff && !stop_ff) begin
            if (square > SQ_W'(test_ff)) begin
               stop_in = 1'b1;
            end else begin
               inj_valid = 1'b1;
            end
         end
         if (chain_status.hit) begin
            found_in = 1'b1;
            stop_in  = 1'b1;
         end
      end

      unique case (state_ff)
         ST_SEED: begin
            mem_we        = 1'b1;
            mem_waddr     = '0;
            mem_wdata     = PRIME_W'(FIRST_PRIME);
            fill_count_in = CW'(1);
            test_in       = NUMBER_W'(FIRST_CANDIDATE);
            k_in          = '0;
            stop_in       = 1'b0;
            found_in      = 1'b0;
            state_in      = ST_CAND_RUN;
         end
         ST_CAND_RUN: begin
            if (run_done) begin
               if (!found_ff) begin
                  mem_we        = 1'b1;
                  fill_count_in = fill_count_ff + CW'(1);
               end
               if (!found_ff && (fill_count_ff == CW'(NUM_PRIMES - 1))) begin
                  state_in = ST_IDLE;
               end else begin
                  test_in  = test_ff + NUMBER_W'(1);
                  k_in     = '0;
                  stop_in  = 1'b0;
                  found_in = 1'b0;
               end
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               test_in = req_number;
               k_in    = '0;
               stop_in = 1'b0;
               if (req_number < NUMBER_W'(MIN_PRIME_NUMBER)) begin
                  found_in = 1'b1;
                  state_in = ST_TEST_END;
               end else begin
                  found_in = 1'b0;
                  state_in = ST_TEST_RUN;
               end
            end
         end
         ST_TEST_RUN: begin
            if (run_done) begin
               state_in = ST_TEST_END;
            end
         end
         ST_TEST_END: begin
            // Hold until the output register is free or being emptied.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_prime_flag_in = !found_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_SEED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SEED;
         k_ff          <= '0;
         stop_ff       <= 1'b0;
         found_ff      <= 1'b0;
         fill_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         rd_valid_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         k_ff          <= k_in;
         stop_ff       <= stop_in;
         found_ff      <= found_in;
         fill_count_ff <= fill_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         rd_valid_ff   <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      test_ff           <= test_in;
      rsp_prime_flag_ff <= rsp_prime_flag_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         prime_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_prime_ff <= prime_mem[k_ff[AW-1:0]];
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_prime_flag = rsp_prime_flag_ff;

endmodule
